// ----- sv/trb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// trb_pkg
// Shared types and constants of the thermostat register block.
// ----------------------------------------------------------------------------
package trb_pkg;

	typedef enum logic [1:0] {
		CMD_READ     = 2'd0,
		CMD_WRITE    = 2'd1,
		CMD_TICK     = 2'd2,
		CMD_TICK_ALT = 2'd3
	} cmd_t;

	typedef logic [3:0]  reg_idx_t;
	typedef logic [15:0] word_t;

	localparam reg_idx_t REG_ADDRESS = 4'd0;
	localparam reg_idx_t REG_HOLDOFF = 4'd1;
	localparam reg_idx_t REG_UP_HI   = 4'd2;
	localparam reg_idx_t REG_UP_LO   = 4'd3;
	localparam reg_idx_t REG_PROBE   = 4'd4;
	localparam reg_idx_t REG_BOARD   = 4'd5;
	localparam reg_idx_t REG_OFF_TH  = 4'd6;
	localparam reg_idx_t REG_ON_TH   = 4'd7;
	localparam reg_idx_t REG_MODE    = 4'd8;
	localparam reg_idx_t REG_HEATER  = 4'd9;
	localparam reg_idx_t REG_PWM     = 4'd11;
	localparam reg_idx_t REG_RESET   = 4'd14;
	localparam reg_idx_t REG_SAVE    = 4'd15;

	localparam word_t DEFAULT_ADDRESS = 16'h0010;
	localparam word_t HOLDOFF_TICKS   = 16'd30;
	localparam word_t RESET_KEY       = 16'hF00F;
	localparam word_t SENSOR_OFF      = 16'hFFFF;
	localparam word_t SAVE_DONE       = 16'h0100;
	localparam word_t SAVE_REFUSED    = 16'hFF00;
	localparam word_t MODE_PROBE      = 16'd4;
	localparam word_t MODE_BOARD      = 16'd5;

	// one accepted request as seen by the register stores
	typedef struct packed {
		logic     valid;
		cmd_t     cmd;
		reg_idx_t idx;
		word_t    wdata;
		word_t    probe;
		word_t    board;
	} trb_req_t;

	typedef struct packed {
		logic  heater_on;
		word_t pwm;
		word_t address;
	} trb_stat_t;

	// registers held in flip-flops because the tick or an output uses them
	function automatic logic is_ctrl_reg(input reg_idx_t idx);
		logic hit;
		unique case (idx)
			REG_ADDRESS, REG_HOLDOFF, REG_UP_HI, REG_UP_LO, REG_PROBE, REG_BOARD,
			REG_OFF_TH, REG_ON_TH, REG_MODE, REG_HEATER, REG_PWM: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

endpackage
`default_nettype wire

// ----- sv/trb_gp_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// trb_gp_ram
// General register storage: one write and one registered read port, with
// per-entry valid bits so unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module trb_gp_ram
	import trb_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     we,
	input  wire reg_idx_t waddr,
	input  wire word_t    wdata,
	input  wire logic     re,
	input  wire reg_idx_t raddr,
	output word_t         rdata
);

	localparam int Depth = 16;

	word_t             mem_q [Depth];
	logic [Depth-1:0]  valid_q;
	word_t             rdata_q;
	logic              rvalid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvalid_q <= valid_q[raddr];
			end
		end
	end

	assign rdata = rvalid_q ? rdata_q : '0;

endmodule
`default_nettype wire

// ----- sv/trb_ctrl_regs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// trb_ctrl_regs
// Control registers with uptime, sensor capture, hold-off and hysteresis.
// ----------------------------------------------------------------------------
module trb_ctrl_regs
	import trb_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire trb_req_t req,
	input  wire reg_idx_t rd_idx,
	output word_t         rd_data,
	output trb_stat_t     stat
);

	word_t addr_q, holdoff_q, up_hi_q, up_lo_q, probe_q, board_q;
	word_t off_th_q, on_th_q, mode_q, heat_q, pwm_q;

	word_t addr_d, holdoff_d, up_hi_d, up_lo_d, probe_d, board_d;
	word_t off_th_d, on_th_d, mode_d, heat_d, pwm_d;

	logic signed [15:0] temp;
	logic               is_tick;

	assign is_tick = (req.cmd == CMD_TICK) || (req.cmd == CMD_TICK_ALT);

	always_comb begin
		addr_d    = addr_q;
		holdoff_d = holdoff_q;
		up_hi_d   = up_hi_q;
		up_lo_d   = up_lo_q;
		probe_d   = probe_q;
		board_d   = board_q;
		off_th_d  = off_th_q;
		on_th_d   = on_th_q;
		mode_d    = mode_q;
		heat_d    = heat_q;
		pwm_d     = pwm_q;
		temp      = '0;
		if (req.valid && req.cmd == CMD_WRITE) begin
			unique case (req.idx)
				REG_ADDRESS: addr_d    = req.wdata;
				REG_HOLDOFF: holdoff_d = req.wdata;
				REG_UP_HI:   up_hi_d   = req.wdata;
				REG_UP_LO:   up_lo_d   = req.wdata;
				REG_PROBE:   probe_d   = req.wdata;
				REG_BOARD:   board_d   = req.wdata;
				REG_OFF_TH:  off_th_d  = req.wdata;
				REG_ON_TH:   on_th_d   = req.wdata;
				REG_MODE:    mode_d    = req.wdata;
				REG_HEATER:  heat_d    = req.wdata;
				REG_PWM:     pwm_d     = req.wdata;
				default:     ;
			endcase
		end else if (req.valid && is_tick) begin
			if (up_lo_q == 16'hFFFF) begin
				up_hi_d = up_hi_q + 16'd1;
				up_lo_d = '0;
			end else begin
				up_lo_d = up_lo_q + 16'd1;
			end
			// a slot holding the off marker keeps it
			if (probe_q != SENSOR_OFF) begin
				probe_d = req.probe;
			end
			if (board_q != SENSOR_OFF) begin
				board_d = req.board;
			end
			temp = $signed((mode_q == MODE_PROBE) ? probe_d : board_d);
			if (holdoff_q != '0) begin
				holdoff_d = holdoff_q - 16'd1;
			end else if (mode_q == MODE_PROBE || mode_q == MODE_BOARD) begin
				if (temp < $signed(on_th_q)) begin
					heat_d = 16'd1;
				end else if (temp > $signed(off_th_q)) begin
					heat_d = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q    <= DEFAULT_ADDRESS;
			holdoff_q <= HOLDOFF_TICKS;
			up_hi_q   <= '0;
			up_lo_q   <= '0;
			probe_q   <= '0;
			board_q   <= '0;
			off_th_q  <= '0;
			on_th_q   <= '0;
			mode_q    <= '0;
			heat_q    <= '0;
			pwm_q     <= '0;
		end else begin
			addr_q    <= addr_d;
			holdoff_q <= holdoff_d;
			up_hi_q   <= up_hi_d;
			up_lo_q   <= up_lo_d;
			probe_q   <= probe_d;
			board_q   <= board_d;
			off_th_q  <= off_th_d;
			on_th_q   <= on_th_d;
			mode_q    <= mode_d;
			heat_q    <= heat_d;
			pwm_q     <= pwm_d;
		end
	end

	always_comb begin
		unique case (rd_idx)
			REG_ADDRESS: rd_data = addr_q;
			REG_HOLDOFF: rd_data = holdoff_q;
			REG_UP_HI:   rd_data = up_hi_q;
			REG_UP_LO:   rd_data = up_lo_q;
			REG_PROBE:   rd_data = probe_q;
			REG_BOARD:   rd_data = board_q;
			REG_OFF_TH:  rd_data = off_th_q;
			REG_ON_TH:   rd_data = on_th_q;
			REG_MODE:    rd_data = mode_q;
			REG_HEATER:  rd_data = heat_q;
			REG_PWM:     rd_data = pwm_q;
			default:     rd_data = '0;
		endcase
	end

	assign stat.heater_on = (heat_q != '0);
	assign stat.pwm       = pwm_q;
	assign stat.address   = addr_q;

endmodule
`default_nettype wire

// ----- sv/thermostat_register_block.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// thermostat_register_block
// Hysteresis thermostat behind sixteen 16-bit registers.
// ----------------------------------------------------------------------------
// One request is taken every cycle unless a stalled result is held; the
// result shows in the next cycle, memory data from its registered read.
// The output stage frees itself in the cycle its result is taken, so a new
// request is accepted alongside. Registers used by the tick or the outputs
// live in flip-flops; the rest sit in a small memory whose unwritten
// entries read as zero after reset, so no clearing pass is needed.
module thermostat_register_block
	import trb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  command,
	input  wire logic [3:0]  reg_index,
	input  wire logic [15:0] write_value,
	input  wire logic signed [15:0] probe_temp,
	input  wire logic signed [15:0] board_temp,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      read_data,
	output logic             heater_on,
	output logic [15:0]      pwm_compare,
	output logic [15:0]      device_address,
	output logic             reset_request,
	output logic             save_request
);

	trb_req_t  req;
	trb_stat_t stat;
	logic      accept;
	logic      gp_hit;
	word_t     stored_val;
	word_t     ctrl_rdata;
	word_t     gp_rdata;

	logic      v_s1;
	cmd_t      cmd_s1;
	reg_idx_t  idx_s1;
	word_t     wdata_s1;
	logic      rst_s1;
	logic      save_s1;

	assign in_ready = !v_s1 || out_ready;
	assign accept   = in_valid && in_ready;

	assign req.valid = accept;
	assign req.cmd   = cmd_t'(command);
	assign req.idx   = reg_index;
	assign req.wdata = write_value;
	assign req.probe = probe_temp;
	assign req.board = board_temp;

	assign gp_hit = !is_ctrl_reg(reg_index);

	// the save register resolves to done or refused against the address
	always_comb begin
		if (reg_index == REG_SAVE) begin
			stored_val = (write_value == stat.address) ? SAVE_DONE : SAVE_REFUSED;
		end else begin
			stored_val = write_value;
		end
	end

	trb_ctrl_regs u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_idx  (idx_s1),
		.rd_data (ctrl_rdata),
		.stat    (stat)
	);

	trb_gp_ram u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (accept && req.cmd == CMD_WRITE && gp_hit),
		.waddr  (reg_index),
		.wdata  (stored_val),
		.re     (accept && req.cmd == CMD_READ),
		.raddr  (reg_index),
		.rdata  (gp_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= req.cmd;
			idx_s1   <= reg_index;
			wdata_s1 <= stored_val;
			rst_s1   <= (req.cmd == CMD_WRITE) && (reg_index == REG_RESET)
			            && (write_value == RESET_KEY);
			save_s1  <= (req.cmd == CMD_WRITE) && (reg_index == REG_SAVE)
			            && (write_value == stat.address);
		end
	end

	// control registers are read live: nothing changes them until this result goes
	always_comb begin
		unique case (cmd_s1)
			CMD_READ:  read_data = is_ctrl_reg(idx_s1) ? ctrl_rdata : gp_rdata;
			CMD_WRITE: read_data = wdata_s1;
			default:   read_data = '0;
		endcase
	end

	assign out_valid      = v_s1;
	assign heater_on      = stat.heater_on;
	assign pwm_compare    = stat.pwm;
	assign device_address = stat.address;
	assign reset_request  = rst_s1;
	assign save_request   = save_s1;

endmodule
`default_nettype wire

// ----- sv/trb_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// trb_checker
// Port-level checks of the thermostat register block, bound to the top.
// ----------------------------------------------------------------------------
module trb_checker
	import trb_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] read_data,
	input wire logic        reset_request,
	input wire logic        save_request
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data))
		else $error("stalled result changed");

	a_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted request gave no result next cycle");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("request refused with output stage free");

	a_reset_val: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reset_request |-> read_data == RESET_KEY && !save_request)
		else $error("reset request without reset key");

	a_save_val: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && save_request |-> read_data == SAVE_DONE)
		else $error("save request without save done value");

endmodule

bind thermostat_register_block trb_checker u_trb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.read_data     (read_data),
	.reset_request (reset_request),
	.save_request  (save_request)
);
`default_nettype wire
